// ===== rtl/mgch_pkg.sv =====
// ----------------------------------------------------------------------------
// mgch_pkg: shared constants and types
// Field widths, register indexes, gain binning constants and the divider
// request/response types of the multi-gate charge histogrammer.
// ----------------------------------------------------------------------------
package mgch_pkg;

   localparam int unsigned SPW_DEFAULT        = 1024;
   localparam int unsigned GATE_COUNT_DEFAULT = 5;

   localparam int unsigned HIST_BINS = 200;
   localparam int unsigned ADC_BITS  = 12;

   localparam int unsigned SAMPLE_W  = 12;
   localparam int unsigned CFG_W     = 10;
   localparam int unsigned CSR_IDX_W = 4;
   localparam int unsigned SUM_W     = 22;
   localparam int unsigned CHARGE_W  = 36;
   localparam int unsigned GIDX_W    = 3;
   localparam int unsigned BIN_W     = 8;
   localparam int unsigned MODE_W    = 7;
   localparam int unsigned COUNT_W   = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_TRIGGER_DELAY  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BASELINE_WIDTH = 4'd1;
   localparam int unsigned          REG_GATE0          = 2;

   localparam int unsigned GATE_BASE_WIDTH = 25;
   localparam int unsigned TRIG_RESET      = 105;
   localparam int unsigned BW_RESET        = 50;

   // operation and result kind codes
   localparam logic OP_SAMPLE   = 1'b0;
   localparam logic OP_REPORT   = 1'b1;
   localparam logic KIND_CHARGE = 1'b0;
   localparam logic KIND_MODE   = 1'b1;

   // peak window of the mode search
   localparam int unsigned PEAK_LO = (13 * HIST_BINS) / 55 - 1;
   localparam int unsigned PEAK_HI = (25 * HIST_BINS) / 55 - 1;

   // gain = (1000*charge + 819200*bw) / (DEN_SCALE*bw)
   localparam int unsigned GAIN_SCALE  = 1000;
   localparam int unsigned GAIN_OFFSET = 819200;
   localparam int unsigned DEN_SCALE   = 9011200 / HIST_BINS;

   // shared multiplier and divider widths
   localparam int unsigned MUL_A_W = 37;
   localparam int unsigned MUL_B_W = 11;
   localparam int unsigned PROD_W  = 48;
   localparam int unsigned QUOT_W  = 8;
   localparam int unsigned DEN_W   = 26;
   localparam int unsigned NUM_W   = DEN_W + QUOT_W;

   typedef struct packed {
      logic              start;
      logic [NUM_W-1:0]  numer;
      logic [DEN_W-1:0]  denom;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quot;
   } div_rsp_type;

endpackage

// ===== rtl/mgch_if.sv =====
// ----------------------------------------------------------------------------
// mgch_if: channel interfaces
// Sample/report requests, results and register writes, each a valid/ready
// channel with source and sink modports.
// ----------------------------------------------------------------------------
interface mgch_req_if import mgch_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                operation;
   logic [SAMPLE_W-1:0] sample_value;
   logic                end_of_waveform;

   modport source (output valid, operation, sample_value, end_of_waveform, input ready);
   modport sink   (input valid, operation, sample_value, end_of_waveform, output ready);
endinterface

interface mgch_rsp_if import mgch_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       result_kind;
   logic [GIDX_W-1:0]          gate_index;
   logic signed [CHARGE_W-1:0] scaled_charge;
   logic [BIN_W-1:0]           gain_bin;
   logic                       in_range;
   logic [MODE_W-1:0]          mode_bin;
   logic [COUNT_W-1:0]         mode_count;
   logic                       last_result;

   modport source (output valid, result_kind, gate_index, scaled_charge, gain_bin,
                   in_range, mode_bin, mode_count, last_result, input ready);
   modport sink   (input valid, result_kind, gate_index, scaled_charge, gain_bin,
                   in_range, mode_bin, mode_count, last_result, output ready);
endinterface

interface mgch_csr_if import mgch_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/mgch_ram.sv =====
// ----------------------------------------------------------------------------
// mgch_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mgch_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/mgch_div.sv =====
// ----------------------------------------------------------------------------
// mgch_div: iterative restoring divider
// Produces a QUOT_W-bit quotient, one bit per cycle, for a numerator known
// to be below denom << QUOT_W.
// ----------------------------------------------------------------------------
module mgch_div import mgch_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam int unsigned CW = $clog2(QUOT_W);

   logic [NUM_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [NUM_W-1:0]  shifted;
   logic [NUM_W:0]    trial;

   assign shifted = NUM_W'(den_ff) << cnt_ff;
   assign trial   = {1'b0, rem_ff} - {1'b0, shifted};

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = req.numer;
         den_in  = req.denom;
         quot_in = '0;
         cnt_in  = CW'(QUOT_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // take the reduced remainder and set the quotient bit when the shifted divisor fits
         if (!trial[NUM_W]) begin
            rem_in          = trial[NUM_W-1:0];
            quot_in[cnt_ff] = 1'b1;
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

endmodule

// ===== rtl/multi_gate_charge_histogrammer.sv =====
// ----------------------------------------------------------------------------
// multi_gate_charge_histogrammer: gated charge integrator with gain histograms
// Sums baseline and gate windows over each waveform, emits one baseline-
// subtracted charge per gate at the end mark, bins its gain into per-gate
// histograms and reports the peak-window mode of each histogram on request.
//
//   channel  | dir | words carried
//   ---------+-----+---------------------------------------------------
//   req_ch   | in  | operation, sample_value, end_of_waveform
//   rsp_ch   | out | kind, gate, charge, bin, in_range, mode, count, last
//   csr_ch   | in  | register index and 10-bit data, always ready
//
// A sample without end mark leaves the block idle, ready for the next request.
// An end-marked sample runs, per gate, three passes through the shared
// multiplier and, for an in-range gain, eight divider steps and a histogram
// read-modify-write. A report reads, per gate, one histogram RAM word per bin
// of the 44-bin peak window, then passes a drain state and the output state.
// After reset a clearing pass zeroes all GATE_COUNT*200 histogram RAM words;
// req_ch is not ready meanwhile. A stalled rsp_ch holds the block in place.
// ----------------------------------------------------------------------------
module multi_gate_charge_histogrammer import mgch_pkg::*; #(
   parameter int unsigned SAMPLES_PER_WAVEFORM = SPW_DEFAULT,
   parameter int unsigned GATE_COUNT           = GATE_COUNT_DEFAULT
) (
   input logic          clock,
   input logic          reset,
   mgch_req_if.sink     req_ch,
   mgch_rsp_if.source   rsp_ch,
   mgch_csr_if.sink     csr_ch
);

   localparam int unsigned GIW   = (GATE_COUNT > 1) ? $clog2(GATE_COUNT) : 1;
   localparam int unsigned DEPTH = GATE_COUNT * HIST_BINS;
   localparam int unsigned AW    = $clog2(DEPTH);
   localparam int unsigned PW    = $clog2(SAMPLES_PER_WAVEFORM + 1);
   localparam int unsigned XW    = ((PW > CFG_W) ? PW : CFG_W) + 2;
   localparam logic [GIW-1:0] LAST_GATE = GIW'(GATE_COUNT - 1);

   localparam logic [3:0] ST_CLR  = 4'd0;
   localparam logic [3:0] ST_IDLE = 4'd1;
   localparam logic [3:0] ST_CA   = 4'd2;
   localparam logic [3:0] ST_CB   = 4'd3;
   localparam logic [3:0] ST_CN   = 4'd4;
   localparam logic [3:0] ST_CK   = 4'd5;
   localparam logic [3:0] ST_DV   = 4'd6;
   localparam logic [3:0] ST_WR   = 4'd7;
   localparam logic [3:0] ST_SCAN = 4'd8;
   localparam logic [3:0] ST_SDRN = 4'd9;
   localparam logic [3:0] ST_OUT  = 4'd10;

   logic [3:0]              state_ff, state_in;
   logic [GIW-1:0]          gate_ff, gate_in;
   logic [AW-1:0]           base_ff, base_in;
   logic [AW-1:0]           clr_ff, clr_in;
   logic [AW-1:0]           hist_addr_ff, hist_addr_in;
   logic [MODE_W-1:0]       scan_ff, scan_in;
   logic                    rdv_ff, rdv_in;
   logic [MODE_W-1:0]       rdbin_ff, rdbin_in;
   logic [MODE_W-1:0]       best_bin_ff, best_bin_in;
   logic [COUNT_W-1:0]      best_cnt_ff, best_cnt_in;

   logic [CFG_W-1:0]        trig_ff, trig_in;
   logic [CFG_W-1:0]        bw_ff, bw_in;
   logic [CFG_W-1:0]        gw_ff [GATE_COUNT];
   logic [CFG_W-1:0]        gw_in [GATE_COUNT];
   logic [PW-1:0]           pos_ff, pos_in;
   logic [SUM_W-1:0]        bsum_ff, bsum_in;
   logic [SUM_W-1:0]        gsum_ff [GATE_COUNT];
   logic [SUM_W-1:0]        gsum_in [GATE_COUNT];

   logic signed [PROD_W-1:0]   t_ff, t_in;
   logic signed [CHARGE_W-1:0] charge_ff, charge_in;
   logic signed [PROD_W-1:0]   num_ff, num_in;
   logic [DEN_W-1:0]           den_ff, den_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_kind_ff, rsp_kind_in;
   logic [GIDX_W-1:0]          rsp_gidx_ff, rsp_gidx_in;
   logic signed [CHARGE_W-1:0] rsp_charge_ff, rsp_charge_in;
   logic [BIN_W-1:0]           rsp_bin_ff, rsp_bin_in;
   logic                       rsp_inr_ff, rsp_inr_in;
   logic [MODE_W-1:0]          rsp_mbin_ff, rsp_mbin_in;
   logic [COUNT_W-1:0]         rsp_mcnt_ff, rsp_mcnt_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]   prod;
   logic signed [PROD_W-1:0]   diff;
   logic [PROD_W-1:0]          offset;
   logic [NUM_W-1:0]           num_lim;
   logic                       in_rng;

   logic                       ram_we, ram_re;
   logic [AW-1:0]              ram_wa, ram_ra;
   logic [COUNT_W-1:0]         ram_wd, ram_q;

   div_req_type                div_req;
   div_rsp_type                div_rsp;

   logic [CFG_W-1:0]           gw_cur;
   logic [SUM_W-1:0]           gsum_cur;
   logic [SUM_W-1:0]           sample_ext;
   logic [XW-1:0]              pos_x, trig_x, bw_x;
   logic                       req_fire, csr_fire, rsp_fire;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign csr_fire = csr_ch.valid && csr_ch.ready;
   assign rsp_fire = rsp_ch.valid && rsp_ch.ready;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;

   assign gw_cur     = gw_ff[gate_ff];
   assign gsum_cur   = gsum_ff[gate_ff];
   assign sample_ext = SUM_W'(req_ch.sample_value[ADC_BITS-1:0]);
   assign pos_x      = XW'(pos_ff);
   assign trig_x     = XW'(trig_ff);
   assign bw_x       = XW'(bw_ff);

   // shared multiplier, operands steered by the sequencer
   always_comb begin
      case (state_ff)
         ST_CA: begin
            mul_a = MUL_A_W'($signed({1'b0, bsum_ff}));
            mul_b = $signed({1'b0, gw_cur});
         end
         ST_CB: begin
            mul_a = MUL_A_W'($signed({1'b0, gsum_cur}));
            mul_b = $signed({1'b0, bw_ff});
         end
         default: begin
            mul_a = MUL_A_W'(charge_ff);
            mul_b = $signed(MUL_B_W'(GAIN_SCALE));
         end
      endcase
   end

   assign prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign diff    = t_ff - prod;
   assign offset  = PROD_W'(bw_ff) * PROD_W'(GAIN_OFFSET);
   assign num_lim = {den_ff, {QUOT_W{1'b0}}};
   assign in_rng  = (bw_ff != '0) && !num_ff[PROD_W-1]
                    && (num_ff[PROD_W-2:NUM_W] == '0)
                    && (num_ff[NUM_W-1:0] < num_lim);

   always_comb begin
      state_in     = state_ff;
      gate_in      = gate_ff;
      base_in      = base_ff;
      clr_in       = clr_ff;
      hist_addr_in = hist_addr_ff;
      scan_in      = scan_ff;
      rdv_in       = rdv_ff;
      rdbin_in     = rdbin_ff;
      best_bin_in  = best_bin_ff;
      best_cnt_in  = best_cnt_ff;
      trig_in      = trig_ff;
      bw_in        = bw_ff;
      pos_in       = pos_ff;
      bsum_in      = bsum_ff;
      for (int g = 0; g < GATE_COUNT; g++) begin
         gw_in[g]   = gw_ff[g];
         gsum_in[g] = gsum_ff[g];
      end
      t_in          = t_ff;
      charge_in     = charge_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_gidx_in   = rsp_gidx_ff;
      rsp_charge_in = rsp_charge_ff;
      rsp_bin_in    = rsp_bin_ff;
      rsp_inr_in    = rsp_inr_ff;
      rsp_mbin_in   = rsp_mbin_ff;
      rsp_mcnt_in   = rsp_mcnt_ff;
      rsp_last_in   = rsp_last_ff;
      ram_we        = 1'b0;
      ram_wa        = clr_ff;
      ram_wd        = '0;
      ram_re        = 1'b0;
      ram_ra        = base_ff;
      div_req.start = 1'b0;
      div_req.numer = num_ff[NUM_W-1:0];
      div_req.denom = den_ff;

      if (csr_fire) begin
         if (csr_ch.index == REG_TRIGGER_DELAY) begin
            trig_in = csr_ch.data;
         end
         if (csr_ch.index == REG_BASELINE_WIDTH) begin
            bw_in = csr_ch.data;
         end
         for (int g = 0; g < GATE_COUNT; g++) begin
            if (csr_ch.index == CSR_IDX_W'(REG_GATE0 + g)) begin
               gw_in[g] = csr_ch.data;
            end
         end
      end

      // peak search: the first bin of the window always seeds the maximum
      if (rdv_ff && ((rdbin_ff == MODE_W'(PEAK_LO)) || (ram_q > best_cnt_ff))) begin
         best_bin_in = rdbin_ff;
         best_cnt_in = ram_q;
      end

      case (state_ff)
         ST_CLR: begin
            ram_we = 1'b1;
            ram_wa = clr_ff;
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               gate_in = '0;
               base_in = '0;
               if (req_ch.operation == OP_REPORT) begin
                  scan_in  = MODE_W'(PEAK_LO);
                  rdv_in   = 1'b0;
                  state_in = ST_SCAN;
               end else begin
                  if (pos_x < XW'(SAMPLES_PER_WAVEFORM)) begin
                     if ((pos_x < trig_x) && (pos_x + bw_x >= trig_x)) begin
                        bsum_in = bsum_ff + sample_ext;
                     end
                     for (int g = 0; g < GATE_COUNT; g++) begin
                        if ((pos_x >= trig_x) && (pos_x < trig_x + XW'(gw_ff[g]))) begin
                           gsum_in[g] = gsum_ff[g] + sample_ext;
                        end
                     end
                     pos_in = pos_ff + 1'b1;
                  end
                  if (req_ch.end_of_waveform) begin
                     state_in = ST_CA;
                  end
               end
            end
         end
         ST_CA: begin
            t_in     = prod;
            state_in = ST_CB;
         end
         ST_CB: begin
            charge_in = $signed(diff[CHARGE_W-1:0]);
            state_in  = ST_CN;
         end
         ST_CN: begin
            num_in   = prod + $signed(offset);
            den_in   = DEN_W'(32'(bw_ff) * DEN_SCALE);
            state_in = ST_CK;
         end
         ST_CK: begin
            rsp_kind_in   = KIND_CHARGE;
            rsp_gidx_in   = GIDX_W'(gate_ff);
            rsp_charge_in = charge_ff;
            rsp_bin_in    = '0;
            rsp_inr_in    = 1'b0;
            rsp_mbin_in   = '0;
            rsp_mcnt_in   = '0;
            rsp_last_in   = (gate_ff == LAST_GATE);
            if (in_rng) begin
               div_req.start = 1'b1;
               state_in      = ST_DV;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = ST_OUT;
            end
         end
         ST_DV: begin
            if (div_rsp.done) begin
               if (div_rsp.quot < BIN_W'(HIST_BINS)) begin
                  ram_re       = 1'b1;
                  ram_ra       = base_ff + AW'(div_rsp.quot);
                  hist_addr_in = base_ff + AW'(div_rsp.quot);
                  rsp_bin_in   = div_rsp.quot;
                  rsp_inr_in   = 1'b1;
                  state_in     = ST_WR;
               end else begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_OUT;
               end
            end
         end
         ST_WR: begin
            // saturate the count at all ones
            ram_we       = 1'b1;
            ram_wa       = hist_addr_ff;
            ram_wd       = (ram_q == '1) ? ram_q : ram_q + 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_OUT;
         end
         ST_SCAN: begin
            ram_re   = 1'b1;
            ram_ra   = base_ff + AW'(scan_ff);
            rdv_in   = 1'b1;
            rdbin_in = scan_ff;
            if (scan_ff == MODE_W'(PEAK_HI)) begin
               state_in = ST_SDRN;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_SDRN: begin
            rdv_in        = 1'b0;
            rsp_kind_in   = KIND_MODE;
            rsp_gidx_in   = GIDX_W'(gate_ff);
            rsp_charge_in = '0;
            rsp_bin_in    = '0;
            rsp_inr_in    = 1'b0;
            rsp_mbin_in   = best_bin_in;
            rsp_mcnt_in   = best_cnt_in;
            rsp_last_in   = (gate_ff == LAST_GATE);
            rsp_valid_in  = 1'b1;
            state_in      = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ch.ready) begin
               rsp_valid_in = 1'b0;
               if (gate_ff == LAST_GATE) begin
                  state_in = ST_IDLE;
                  if (rsp_kind_ff == KIND_CHARGE) begin
                     pos_in  = '0;
                     bsum_in = '0;
                     for (int g = 0; g < GATE_COUNT; g++) begin
                        gsum_in[g] = '0;
                     end
                  end
               end else begin
                  gate_in = gate_ff + 1'b1;
                  base_in = base_ff + AW'(HIST_BINS);
                  if (rsp_kind_ff == KIND_CHARGE) begin
                     state_in = ST_CA;
                  end else begin
                     scan_in  = MODE_W'(PEAK_LO);
                     rdv_in   = 1'b0;
                     state_in = ST_SCAN;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         gate_ff      <= '0;
         base_ff      <= '0;
         clr_ff       <= '0;
         scan_ff      <= '0;
         rdv_ff       <= 1'b0;
         trig_ff      <= CFG_W'(TRIG_RESET);
         bw_ff        <= CFG_W'(BW_RESET);
         pos_ff       <= '0;
         bsum_ff      <= '0;
         for (int g = 0; g < GATE_COUNT; g++) begin
            gw_ff[g]   <= CFG_W'(GATE_BASE_WIDTH * (g + 1));
            gsum_ff[g] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gate_ff      <= gate_in;
         base_ff      <= base_in;
         clr_ff       <= clr_in;
         scan_ff      <= scan_in;
         rdv_ff       <= rdv_in;
         trig_ff      <= trig_in;
         bw_ff        <= bw_in;
         pos_ff       <= pos_in;
         bsum_ff      <= bsum_in;
         for (int g = 0; g < GATE_COUNT; g++) begin
            gw_ff[g]   <= gw_in[g];
            gsum_ff[g] <= gsum_in[g];
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      hist_addr_ff  <= hist_addr_in;
      rdbin_ff      <= rdbin_in;
      best_bin_ff   <= best_bin_in;
      best_cnt_ff   <= best_cnt_in;
      t_ff          <= t_in;
      charge_ff     <= charge_in;
      num_ff        <= num_in;
      den_ff        <= den_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_gidx_ff   <= rsp_gidx_in;
      rsp_charge_ff <= rsp_charge_in;
      rsp_bin_ff    <= rsp_bin_in;
      rsp_inr_ff    <= rsp_inr_in;
      rsp_mbin_ff   <= rsp_mbin_in;
      rsp_mcnt_ff   <= rsp_mcnt_in;
      rsp_last_ff   <= rsp_last_in;
   end

   mgch_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (DEPTH)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_q)
   );

   mgch_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.result_kind   = rsp_kind_ff;
   assign rsp_ch.gate_index    = rsp_gidx_ff;
   assign rsp_ch.scaled_charge = rsp_charge_ff;
   assign rsp_ch.gain_bin      = rsp_bin_ff;
   assign rsp_ch.in_range      = rsp_inr_ff;
   assign rsp_ch.mode_bin      = rsp_mbin_ff;
   assign rsp_ch.mode_count    = rsp_mcnt_ff;
   assign rsp_ch.last_result   = rsp_last_ff;

`ifndef SYNTHESIS
   a_valid_in_out: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (state_ff == ST_OUT))
      else $error("result word shown outside output state");

   a_last_gate: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.last_result) |-> (gate_ff == LAST_GATE))
      else $error("last flag on a gate other than the final one");

   a_sums_cleared: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_ch.last_result && (rsp_ch.result_kind == KIND_CHARGE))
      |=> ((bsum_ff == '0) && (pos_ff == '0)))
      else $error("waveform sums not cleared after final charge word");

   a_mode_window: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.result_kind == KIND_MODE))
      |-> ((rsp_ch.mode_bin >= MODE_W'(PEAK_LO)) && (rsp_ch.mode_bin <= MODE_W'(PEAK_HI))))
      else $error("mode bin outside peak window");

   a_bin_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.in_range) |-> (rsp_ch.gain_bin < BIN_W'(HIST_BINS)))
      else $error("in-range gain bin beyond histogram");
`endif

endmodule

// ===== tb/multi_gate_charge_histogrammer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_gate_charge_histogrammer_tb: self-checking bench of the histogrammer
// Streams waveforms and mode reports under random source and sink idling,
// predicts every charge, gain bin and histogram mode in the bench, and
// compares each result word with the oldest prediction.
// ----------------------------------------------------------------------------
module multi_gate_charge_histogrammer_tb;
   import mgch_pkg::*;

   localparam int NGATES  = GATE_COUNT_DEFAULT;
   localparam int NBINS   = HIST_BINS;
   localparam int SETTLE  = 800;
   localparam int MAX_ERR = 10;

   // waveform shapes
   localparam int SHAPE_RANDOM = 0;
   localparam int SHAPE_FLAT   = 1;
   localparam int SHAPE_PULSE  = 2;

   typedef struct packed {
      logic                       kind;
      logic [GIDX_W-1:0]          gate;
      logic signed [CHARGE_W-1:0] charge;
      logic [BIN_W-1:0]           bin;
      logic                       inr;
      logic [MODE_W-1:0]          mbin;
      logic [COUNT_W-1:0]         mcount;
      logic                       last;
   } result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mgch_req_if req_ch ();
   mgch_rsp_if rsp_ch ();
   mgch_csr_if csr_ch ();

   multi_gate_charge_histogrammer dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   always #5 clock = ~clock;

   // predictor state
   int unsigned      trig_delay;
   int unsigned      base_width;
   int unsigned      gate_width [NGATES];
   int unsigned      position;
   logic [SUM_W-1:0] base_sum;
   logic [SUM_W-1:0] gate_sum [NGATES];
   logic [31:0]      gain_hist [NGATES][NBINS];

   result_type expected_results [$];
   int         mismatches = 0;
   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;

   function automatic result_type mode_result(int g);
      result_type r;
      int best;
      best = PEAK_LO;
      for (int b = PEAK_LO; b <= PEAK_HI; b++)
         if (gain_hist[g][b] > gain_hist[g][best]) best = b;
      r = '0;
      r.kind   = KIND_MODE;
      r.gate   = GIDX_W'(g);
      r.mbin   = MODE_W'(best);
      r.mcount = gain_hist[g][best];
      r.last   = (g == NGATES - 1);
      return r;
   endfunction

   task automatic predict_item(logic op, logic [SAMPLE_W-1:0] val, logic eow);
      result_type r;
      longint  raw, chg, num, den, q;
      logic [CHARGE_W-1:0] wrapped;
      if (op == OP_REPORT) begin
         for (int g = 0; g < NGATES; g++) expected_results.push_back(mode_result(g));
         return;
      end
      if (position < SPW_DEFAULT) begin
         if (position < trig_delay && position + base_width >= trig_delay)
            base_sum = base_sum + SUM_W'(val);
         for (int g = 0; g < NGATES; g++)
            if (position >= trig_delay && position < trig_delay + gate_width[g])
               gate_sum[g] = gate_sum[g] + SUM_W'(val);
         position++;
      end
      if (!eow) return;
      for (int g = 0; g < NGATES; g++) begin
         raw = longint'(gate_width[g]) * longint'(base_sum)
             - longint'(base_width) * longint'(gate_sum[g]);
         wrapped = raw[CHARGE_W-1:0];
         chg = longint'(signed'(wrapped));
         r = '0;
         r.kind   = KIND_CHARGE;
         r.gate   = GIDX_W'(g);
         r.charge = wrapped;
         r.last   = (g == NGATES - 1);
         if (base_width > 0) begin
            num = (1000 * chg + 819200 * longint'(base_width)) * NBINS;
            den = 9011200 * longint'(base_width);
            if (num >= 0) begin
               q = num / den;
               if (q < NBINS) begin
                  if (gain_hist[g][q] != 32'hFFFF_FFFF) gain_hist[g][q]++;
                  r.bin = BIN_W'(q);
                  r.inr = 1'b1;
               end
            end
         end
         expected_results.push_back(r);
      end
      position = 0;
      base_sum = '0;
      foreach (gate_sum[g]) gate_sum[g] = '0;
   endtask

   // leaves valid high on return; drain() takes it down, the next call only while it idles
   task automatic send_item(logic op, logic [SAMPLE_W-1:0] val, logic eow);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.operation       <= op;
      req_ch.sample_value    <= val;
      req_ch.end_of_waveform <= eow;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_item(op, val, eow);
      @(negedge clock);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int unsigned v);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= v[CFG_W-1:0];
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      case (idx)
         REG_TRIGGER_DELAY:  trig_delay = 32'(v[CFG_W-1:0]);
         REG_BASELINE_WIDTH: base_width = 32'(v[CFG_W-1:0]);
         default:            gate_width[idx - REG_GATE0] = 32'(v[CFG_W-1:0]);
      endcase
      @(negedge clock);
   endtask

   task automatic set_config(int unsigned d, int unsigned bw, int unsigned w0,
                             int unsigned w1, int unsigned w2, int unsigned w3,
                             int unsigned w4);
      int unsigned w [NGATES];
      w = '{w0, w1, w2, w3, w4};
      drain();
      write_reg(REG_TRIGGER_DELAY, d);
      write_reg(REG_BASELINE_WIDTH, bw);
      for (int g = 0; g < NGATES; g++) write_reg(CSR_IDX_W'(REG_GATE0 + g), w[g]);
      csr_ch.valid <= 1'b0;
   endtask

   // one waveform of len samples in the given shape; pulse steps up at the trigger
   task automatic send_waveform(int len, int shape, int unsigned lvl);
      logic [SAMPLE_W-1:0] v;
      for (int i = 0; i < len; i++) begin
         case (shape)
            SHAPE_RANDOM: v = SAMPLE_W'($urandom);
            SHAPE_FLAT:   v = SAMPLE_W'(lvl);
            default:      v = SAMPLE_W'((i >= trig_delay) ? lvl : lvl / 4);
         endcase
         send_item(OP_SAMPLE, v, i == len - 1);
      end
   endtask

   task automatic test_reset_values();
      // default windows: baseline 55..104, gates from 105
      send_waveform(108, SHAPE_PULSE, 12'h400);
   endtask

   task automatic test_directed();
      set_config(4, 3, 0, 1, 2, 3, 4);
      send_waveform(8, SHAPE_FLAT, 12'hFFF);
      send_waveform(8, SHAPE_FLAT, 0);
      send_waveform(1, SHAPE_FLAT, 12'h800);
      send_item(OP_REPORT, 12'hABC, 1'b1);
      // baseline window would start before position zero
      set_config(2, 1023, 1023, 0, 5, 6, 7);
      send_waveform(10, SHAPE_RANDOM, 0);
      // zero baseline width: nothing binned
      set_config(3, 0, 2, 2, 2, 2, 2);
      send_waveform(6, SHAPE_RANDOM, 0);
      send_item(OP_REPORT, 12'h000, 1'b0);
   endtask

   task automatic test_random_waveforms(int n_items);
      int sent;
      sent = 0;
      while (sent < n_items) begin
         int len;
         int unsigned d, bw;
         d  = $urandom_range(12, 2);
         bw = $urandom_range(d, 1);
         set_config(d, bw, $urandom_range(12), $urandom_range(12), $urandom_range(12),
                    $urandom_range(12), $urandom_range(12));
         repeat (2) begin
            len = $urandom_range(d + 6, 1);
            if ($urandom_range(9) == 0) send_waveform(len, SHAPE_RANDOM, 0);
            else send_waveform(len, SHAPE_PULSE, $urandom_range(4095));
            sent += len;
            if ($urandom_range(3) == 0) begin
               send_item(OP_REPORT, SAMPLE_W'($urandom), 1'($urandom));
               sent++;
            end
         end
      end
   endtask

   // result checker
   always @(posedge clock) begin
      result_type got, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.result_kind, rsp_ch.gate_index, rsp_ch.scaled_charge,
                 rsp_ch.gain_bin, rsp_ch.in_range, rsp_ch.mode_bin,
                 rsp_ch.mode_count, rsp_ch.last_result};
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_ERR) $display("unexpected result word %p", got);
         end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= MAX_ERR)
                  $display("result mismatch: expected %p actual %p", want, got);
            end
         end
      end
   end

   // sink stalls
   always @(negedge clock)
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

   initial begin
      req_ch.valid = 1'b0;
      req_ch.operation = OP_SAMPLE;
      req_ch.sample_value = '0;
      req_ch.end_of_waveform = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      trig_delay = TRIG_RESET;
      base_width = BW_RESET;
      for (int g = 0; g < NGATES; g++) gate_width[g] = GATE_BASE_WIDTH * (g + 1);
      position = 0;
      base_sum = '0;
      foreach (gate_sum[g]) gate_sum[g] = '0;
      foreach (gain_hist[g, b]) gain_hist[g][b] = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_directed();
      send_idle_pct = 10;
      recv_idle_pct = 46;
      test_random_waveforms(12);
      send_idle_pct = 46;
      recv_idle_pct = 10;
      test_random_waveforms(12);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_waveforms(12);
      set_config(0, 1, 1023, 1023, 1023, 1023, 1023);
      send_waveform(4, SHAPE_RANDOM, 0);
      drain();
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/mgch_pkg.sv
rtl/mgch_if.sv
rtl/mgch_ram.sv
rtl/mgch_div.sv
rtl/multi_gate_charge_histogrammer.sv
tb/multi_gate_charge_histogrammer_tb.sv
